[design/hcms_pkg.sv]
// Shared types, constants and helper functions of the hover craft motion step.
`default_nettype none
package hcms_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int POS_WIDTH_DEF = 48;
  localparam int DIR_FRAC = 14;

  localparam logic [32:0] NEAR_VERTICAL_SQ = 33'd268;
  localparam logic [63:0] FORCE_LIM = (64'd1 << 60) - 64'd1;
  localparam logic [63:0] BIG_LIM = (64'd1 << 62) - 64'd1;
  localparam logic [31:0] SPEED_MAX = 32'h7FFF_FFFF;
  localparam logic [63:0] GRAV_Q16 = 64'd642253;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MASS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRAG = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_SCALE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_METER_SCALE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED = 3'd5;

  typedef enum logic [1:0] {
    AOP_NONE,
    AOP_MUL,
    AOP_DIV,
    AOP_SQRT
  } arith_op_t;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_G1, ST_G2,
    ST_HX2, ST_HZ2, ST_HSEL, ST_HSQRT,
    ST_TXM, ST_TXD, ST_TZM, ST_TZD,
    ST_LX, ST_LZ, ST_LIFT,
    ST_DRAG, ST_DX, ST_DY, ST_DZ, ST_FSEL,
    ST_VXA, ST_VXM, ST_VXD,
    ST_VYA, ST_VYM, ST_VYD,
    ST_VZA, ST_VZM, ST_VZD,
    ST_MAG, ST_SHIFT,
    ST_SQX, ST_SQY, ST_SQZ, ST_NSQRT, ST_NSEL, ST_NZERO,
    ST_NDX, ST_NDY, ST_NDZ, ST_NFIN,
    ST_MSEL, ST_U1, ST_U2, ST_PX, ST_PY, ST_PZ,
    ST_OUT
  } step_t;

  typedef struct packed {
    step_t step;
    logic  start;
    logic  go;
    logic  load;
  } cmd_t;

  typedef struct packed {
    logic unit_done;
    logic dead;
    logic no_force;
    logic horiz;
    logic force_nz;
    logic big;
    logic n_zero;
    logic moved;
    logic out_free;
  } status_t;

  function automatic arith_op_t step_op(step_t s);
    case (s)
      ST_G1, ST_G2, ST_HX2, ST_HZ2, ST_TXM, ST_TZM, ST_LX, ST_LZ, ST_DRAG,
      ST_DX, ST_DY, ST_DZ, ST_VXA, ST_VXM, ST_VYA, ST_VYM, ST_VZA, ST_VZM,
      ST_SQX, ST_SQY, ST_SQZ, ST_U1, ST_U2, ST_PX, ST_PY, ST_PZ: return AOP_MUL;
      ST_TXD, ST_TZD, ST_VXD, ST_VYD, ST_VZD, ST_NDX, ST_NDY, ST_NDZ: return AOP_DIV;
      ST_HSQRT, ST_NSQRT: return AOP_SQRT;
      default: return AOP_NONE;
    endcase
  endfunction

  function automatic logic [63:0] shr_sat(logic [127:0] p, int sh, logic [63:0] lim);
    logic [127:0] q;
    q = p >> sh;
    if (q > {64'd0, lim}) begin
      return lim;
    end
    return q[63:0];
  endfunction

  function automatic logic [63:0] div_sat(logic ovf, logic [63:0] q, logic [63:0] lim);
    return (ovf || (q > lim)) ? lim : q;
  endfunction

  function automatic logic signed [63:0] apply_sign(logic neg, logic [63:0] m);
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [63:0] abs64(logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] clampf(logic signed [63:0] v);
    if (v > $signed(FORCE_LIM)) begin
      return $signed(FORCE_LIM);
    end
    if (v < -$signed(FORCE_LIM)) begin
      return -$signed(FORCE_LIM);
    end
    return v;
  endfunction

endpackage
`default_nettype wire

[design/hover_craft_motion_step.sv]
// Top level of the hover craft motion step: sequencer plus datapath.
//
//   Channel  Handshake             Carries
//   in_      in_valid/in_ready     time step, flags, heading, up axis, thrust, lift
//   out_     out_valid/out_ready   position, unit direction, speed, moved flag
//   cfg_     cfg_valid/cfg_ready   register index and 31-bit write data
//
// Every multiply, divide and square root step runs on the single shared unit, one
// operation at a time. Normalizing a large velocity shifts it right one bit at a
// time until every component fits in 31 bits.
// Reset restores the configuration defaults and clears direction, speed and position.
// A finished item waits in the output register; the next item is taken meanwhile
// and holds at its last step only while that register is still occupied.
`default_nettype none
module hover_craft_motion_step #(
  parameter int FRAC_BITS = hcms_pkg::FRAC_BITS_DEF,
  parameter int POS_WIDTH = hcms_pkg::POS_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [hcms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [30:0]                     cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [30:0]                     in_time_step,
  input  wire logic                            in_no_force,
  input  wire logic                            in_dead,
  input  wire logic signed [15:0]              in_heading_x,
  input  wire logic signed [15:0]              in_heading_z,
  input  wire logic signed [15:0]              in_up_x,
  input  wire logic signed [15:0]              in_up_z,
  input  wire logic signed [31:0]              in_thrust,
  input  wire logic signed [31:0]              in_lift,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [POS_WIDTH-1:0]          out_position_x_out,
  output logic signed [POS_WIDTH-1:0]          out_position_y_out,
  output logic signed [POS_WIDTH-1:0]          out_position_z_out,
  output logic signed [15:0]                   out_direction_x_out,
  output logic signed [15:0]                   out_direction_y_out,
  output logic signed [15:0]                   out_direction_z_out,
  output logic [30:0]                          out_speed_out,
  output logic                                 out_moved
);
  import hcms_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  hcms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  hcms_dp #(
    .FRAC_BITS (FRAC_BITS),
    .POS_WIDTH (POS_WIDTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .cfg_valid           (cfg_valid),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_time_step        (in_time_step),
    .in_no_force         (in_no_force),
    .in_dead             (in_dead),
    .in_heading_x        (in_heading_x),
    .in_heading_z        (in_heading_z),
    .in_up_x             (in_up_x),
    .in_up_z             (in_up_z),
    .in_thrust           (in_thrust),
    .in_lift             (in_lift),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_position_x_out  (out_position_x_out),
    .out_position_y_out  (out_position_y_out),
    .out_position_z_out  (out_position_z_out),
    .out_direction_x_out (out_direction_x_out),
    .out_direction_y_out (out_direction_y_out),
    .out_direction_z_out (out_direction_z_out),
    .out_speed_out       (out_speed_out),
    .out_moved           (out_moved)
  );

endmodule
`default_nettype wire

[design/hcms_arith.sv]
// Shared iterative unit: 64x64 shift-add multiply, 128/64 restoring divide, 64-bit square root.
`default_nettype none
module hcms_arith (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire hcms_pkg::arith_op_t  op,
  input  wire logic [63:0]          opa,
  input  wire logic [63:0]          opb,
  input  wire logic [63:0]          opc,
  output logic                      done,
  output logic [63:0]               res_hi,
  output logic [63:0]               res_lo,
  output logic [63:0]               res_q,
  output logic                      ovf
);
  import hcms_pkg::*;

  logic        busy_r;
  logic        done_r;
  arith_op_t   op_r;
  logic [5:0]  cnt_r;
  logic [63:0] acc_hi_r;
  logic [63:0] acc_lo_r;
  logic [63:0] x_r;
  logic [63:0] y_r;
  logic        ovf_r;

  logic [64:0] mul_sum;
  logic [64:0] div_rem;
  logic [64:0] div_dif;
  logic [63:0] sq_try;

  assign mul_sum = {1'b0, acc_hi_r} + (y_r[0] ? {1'b0, x_r} : 65'd0);
  assign div_rem = {acc_hi_r, x_r[63]};
  assign div_dif = div_rem - {1'b0, acc_lo_r};
  assign sq_try = y_r + x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r <= AOP_NONE;
      cnt_r <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == 6'd0);
      if (start) begin
        busy_r <= (op != AOP_NONE);
        op_r <= op;
        cnt_r <= (op == AOP_SQRT) ? 6'd31 : 6'd63;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      case (op)
        AOP_MUL: begin
          acc_hi_r <= '0;
          acc_lo_r <= '0;
          x_r <= opa;
          y_r <= opb;
          ovf_r <= 1'b0;
        end
        AOP_DIV: begin
          acc_hi_r <= opa;
          acc_lo_r <= opc;
          x_r <= opb;
          y_r <= '0;
          ovf_r <= (opa >= opc);
        end
        AOP_SQRT: begin
          acc_hi_r <= opa;
          acc_lo_r <= '0;
          x_r <= 64'd1 << 62;
          y_r <= '0;
          ovf_r <= 1'b0;
        end
        default: begin
          ovf_r <= 1'b0;
        end
      endcase
    end else if (busy_r) begin
      case (op_r)
        AOP_MUL: begin
          acc_hi_r <= mul_sum[64:1];
          acc_lo_r <= {mul_sum[0], acc_lo_r[63:1]};
          y_r <= y_r >> 1;
        end
        AOP_DIV: begin
          x_r <= x_r << 1;
          if (div_rem >= {1'b0, acc_lo_r}) begin
            acc_hi_r <= div_dif[63:0];
            y_r <= {y_r[62:0], 1'b1};
          end else begin
            acc_hi_r <= div_rem[63:0];
            y_r <= {y_r[62:0], 1'b0};
          end
        end
        AOP_SQRT: begin
          x_r <= x_r >> 2;
          if (acc_hi_r >= sq_try) begin
            acc_hi_r <= acc_hi_r - sq_try;
            y_r <= (y_r >> 1) + x_r;
          end else begin
            y_r <= y_r >> 1;
          end
        end
        default: begin
          y_r <= y_r;
        end
      endcase
    end
  end

  assign done = done_r;
  assign res_hi = acc_hi_r;
  assign res_lo = acc_lo_r;
  assign res_q = y_r;
  assign ovf = ovf_r;

endmodule
`default_nettype wire

[design/hcms_ctrl.sv]
// Sequencer that steps the datapath through one motion update.
`default_nettype none
module hcms_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output hcms_pkg::cmd_t         cmd,
  input  wire hcms_pkg::status_t status
);
  import hcms_pkg::*;

  step_t state_r;
  step_t state_nxt;
  logic  run_r;
  logic  is_unit;

  assign is_unit = (step_op(state_r) != AOP_NONE);

  always_comb begin
    state_nxt = state_r;
    if (is_unit) begin
      if (run_r && status.unit_done) begin
        case (state_r)
          ST_G1:    state_nxt = status.dead ? ST_G2 : (status.no_force ? ST_DRAG : ST_HX2);
          ST_G2:    state_nxt = status.no_force ? ST_DRAG : ST_HX2;
          ST_HX2:   state_nxt = ST_HZ2;
          ST_HZ2:   state_nxt = ST_HSEL;
          ST_HSQRT: state_nxt = ST_TXM;
          ST_TXM:   state_nxt = ST_TXD;
          ST_TXD:   state_nxt = ST_TZM;
          ST_TZM:   state_nxt = ST_TZD;
          ST_TZD:   state_nxt = ST_LIFT;
          ST_LX:    state_nxt = ST_LZ;
          ST_LZ:    state_nxt = ST_LIFT;
          ST_DRAG:  state_nxt = ST_DX;
          ST_DX:    state_nxt = ST_DY;
          ST_DY:    state_nxt = ST_DZ;
          ST_DZ:    state_nxt = ST_FSEL;
          ST_VXA:   state_nxt = ST_VXM;
          ST_VXM:   state_nxt = ST_VXD;
          ST_VXD:   state_nxt = ST_VYA;
          ST_VYA:   state_nxt = ST_VYM;
          ST_VYM:   state_nxt = ST_VYD;
          ST_VYD:   state_nxt = ST_VZA;
          ST_VZA:   state_nxt = ST_VZM;
          ST_VZM:   state_nxt = ST_VZD;
          ST_VZD:   state_nxt = ST_MAG;
          ST_SQX:   state_nxt = ST_SQY;
          ST_SQY:   state_nxt = ST_SQZ;
          ST_SQZ:   state_nxt = ST_NSQRT;
          ST_NSQRT: state_nxt = ST_NSEL;
          ST_NDX:   state_nxt = ST_NDY;
          ST_NDY:   state_nxt = ST_NDZ;
          ST_NDZ:   state_nxt = ST_NFIN;
          ST_U1:    state_nxt = ST_U2;
          ST_U2:    state_nxt = ST_PX;
          ST_PX:    state_nxt = ST_PY;
          ST_PY:    state_nxt = ST_PZ;
          ST_PZ:    state_nxt = ST_OUT;
          default:  state_nxt = ST_IDLE;
        endcase
      end
    end else begin
      case (state_r)
        ST_IDLE:  state_nxt = in_valid ? ST_G1 : ST_IDLE;
        ST_HSEL:  state_nxt = status.horiz ? ST_HSQRT : ST_LX;
        ST_LIFT:  state_nxt = ST_DRAG;
        ST_FSEL:  state_nxt = status.force_nz ? ST_VXA : ST_MSEL;
        ST_MAG:   state_nxt = ST_SHIFT;
        ST_SHIFT: state_nxt = status.big ? ST_SHIFT : ST_SQX;
        ST_NSEL:  state_nxt = status.n_zero ? ST_NZERO : ST_NDX;
        ST_NZERO: state_nxt = ST_MSEL;
        ST_NFIN:  state_nxt = ST_MSEL;
        ST_MSEL:  state_nxt = status.moved ? ST_U1 : ST_OUT;
        ST_OUT:   state_nxt = status.out_free ? ST_IDLE : ST_OUT;
        default:  state_nxt = ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.step = state_r;
    cmd.start = is_unit && !run_r;
    cmd.load = (state_r == ST_IDLE) && in_valid;
    case (state_r)
      ST_LIFT, ST_MAG, ST_NZERO, ST_NFIN: cmd.go = 1'b1;
      ST_SHIFT: cmd.go = status.big;
      ST_OUT:   cmd.go = status.out_free;
      default:  cmd.go = 1'b0;
    endcase
    in_ready = (state_r == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      run_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.start) begin
        run_r <= 1'b1;
      end else if (status.unit_done) begin
        run_r <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_done_launched: assert property (@(posedge clk) disable iff (!rst_n)
    status.unit_done |-> run_r)
    else $error("unit finished an operation that was never launched");
  a_single_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> !cmd.start)
    else $error("unit started twice in a row");
  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !in_ready)
    else $error("input still ready after an item was taken");
`endif

endmodule
`default_nettype wire

[design/hcms_dp.sv]
// Datapath: configuration, craft state, scratch registers and the shared arithmetic unit.
`default_nettype none
module hcms_dp #(
  parameter int FRAC_BITS = hcms_pkg::FRAC_BITS_DEF,
  parameter int POS_WIDTH = hcms_pkg::POS_WIDTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire hcms_pkg::cmd_t                        cmd,
  output hcms_pkg::status_t                          status,
  input  wire logic                                  cfg_valid,
  input  wire logic [hcms_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [30:0]                           cfg_data,
  input  wire logic [30:0]                           in_time_step,
  input  wire logic                                  in_no_force,
  input  wire logic                                  in_dead,
  input  wire logic signed [15:0]                    in_heading_x,
  input  wire logic signed [15:0]                    in_heading_z,
  input  wire logic signed [15:0]                    in_up_x,
  input  wire logic signed [15:0]                    in_up_z,
  input  wire logic signed [31:0]                    in_thrust,
  input  wire logic signed [31:0]                    in_lift,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [POS_WIDTH-1:0]                out_position_x_out,
  output logic signed [POS_WIDTH-1:0]                out_position_y_out,
  output logic signed [POS_WIDTH-1:0]                out_position_z_out,
  output logic signed [15:0]                         out_direction_x_out,
  output logic signed [15:0]                         out_direction_y_out,
  output logic signed [15:0]                         out_direction_z_out,
  output logic [30:0]                                out_speed_out,
  output logic                                       out_moved
);
  import hcms_pkg::*;

  localparam logic [30:0] ONE_Q = 31'(64'd1 << FRAC_BITS);
  localparam logic [30:0] GRAV_Q = 31'((GRAV_Q16 << FRAC_BITS) >> 16);

  logic [30:0] mass_r, drag_r, grav_r, dgs_r, meter_r, minspd_r;

  logic [30:0]        t_r;
  logic               dead_r, nof_r;
  logic signed [15:0] hx_r, hz_r, ux_r, uz_r;
  logic signed [31:0] thrust_r, lift_r;

  logic signed [15:0] dx_r, dy_r, dz_r;
  logic [30:0]        speed_r;
  logic [POS_WIDTH-1:0] px_r, py_r, pz_r;

  logic signed [63:0] rx_r, ry_r, rz_r, tmp_r, vx_r, vy_r, vz_r;
  logic [63:0] lwv_r, u_r, ax_r, ay_r, az_r, sq_r;
  logic [32:0] hs_r;
  logic [16:0] nb_r;
  logic [31:0] n_r;
  logic        k_r;

  logic                 out_valid_r;
  logic [POS_WIDTH-1:0] opx_r, opy_r, opz_r;
  logic signed [15:0]   odx_r, ody_r, odz_r;
  logic [30:0]          ospd_r;
  logic                 omoved_r;

  arith_op_t    aop;
  logic [63:0]  opa, opb, opc;
  logic         u_done, u_ovf;
  logic [63:0]  u_hi, u_lo, u_q;
  logic [127:0] prod;
  logic [63:0]  m64;
  logic [63:0]  sh_ff, sh_fd, sh_bf, sh_bd, dv_f, dv_b;
  logic         moved_now;

  assign prod = {u_hi, u_lo};
  assign m64 = (mass_r == 31'd0) ? 64'd1 : 64'(mass_r);
  assign sh_ff = shr_sat(prod, FRAC_BITS, FORCE_LIM);
  assign sh_fd = shr_sat(prod, DIR_FRAC, FORCE_LIM);
  assign sh_bf = shr_sat(prod, FRAC_BITS, BIG_LIM);
  assign sh_bd = shr_sat(prod, DIR_FRAC, BIG_LIM);
  assign dv_f = div_sat(u_ovf, u_q, FORCE_LIM);
  assign dv_b = div_sat(u_ovf, u_q, BIG_LIM);
  assign moved_now = (speed_r > minspd_r);

  always_comb begin
    aop = step_op(cmd.step);
    opa = '0;
    opb = '0;
    opc = '0;
    case (cmd.step)
      ST_G1:    begin opa = 64'(grav_r); opb = m64; end
      ST_G2:    begin opa = 64'(ry_r); opb = 64'(dgs_r); end
      ST_HX2:   begin opa = abs64(64'(hx_r)); opb = abs64(64'(hx_r)); end
      ST_HZ2:   begin opa = abs64(64'(hz_r)); opb = abs64(64'(hz_r)); end
      ST_HSQRT: begin opa = 64'(hs_r); end
      ST_TXM:   begin opa = abs64(64'(thrust_r)); opb = abs64(64'(hx_r)); end
      ST_TZM:   begin opa = abs64(64'(thrust_r)); opb = abs64(64'(hz_r)); end
      ST_TXD, ST_TZD: begin opa = u_hi; opb = u_lo; opc = 64'(nb_r); end
      ST_LX:    begin opa = abs64(64'(ux_r)); opb = abs64(64'(lift_r)); end
      ST_LZ:    begin opa = abs64(64'(uz_r)); opb = abs64(64'(lift_r)); end
      ST_DRAG:  begin opa = 64'(speed_r); opb = 64'(drag_r); end
      ST_DX:    begin opa = abs64(64'(dx_r)); opb = lwv_r; end
      ST_DY:    begin opa = abs64(64'(dy_r)); opb = lwv_r; end
      ST_DZ:    begin opa = abs64(64'(dz_r)); opb = lwv_r; end
      ST_VXA:   begin opa = abs64(64'(dx_r)); opb = 64'(speed_r); end
      ST_VYA:   begin opa = abs64(64'(dy_r)); opb = 64'(speed_r); end
      ST_VZA:   begin opa = abs64(64'(dz_r)); opb = 64'(speed_r); end
      ST_VXM:   begin opa = abs64(rx_r); opb = 64'(t_r); end
      ST_VYM:   begin opa = abs64(ry_r); opb = 64'(t_r); end
      ST_VZM:   begin opa = abs64(rz_r); opb = 64'(t_r); end
      ST_VXD, ST_VYD, ST_VZD: begin opa = u_hi; opb = u_lo; opc = m64; end
      ST_SQX:   begin opa = ax_r; opb = ax_r; end
      ST_SQY:   begin opa = ay_r; opb = ay_r; end
      ST_SQZ:   begin opa = az_r; opb = az_r; end
      ST_NSQRT: begin opa = sq_r; end
      ST_NDX:   begin opb = ax_r << DIR_FRAC; opc = 64'(n_r); end
      ST_NDY:   begin opb = ay_r << DIR_FRAC; opc = 64'(n_r); end
      ST_NDZ:   begin opb = az_r << DIR_FRAC; opc = 64'(n_r); end
      ST_U1:    begin opa = 64'(speed_r); opb = 64'(t_r); end
      ST_U2:    begin opa = u_r; opb = 64'(meter_r); end
      ST_PX:    begin opa = abs64(64'(dx_r)); opb = u_r; end
      ST_PY:    begin opa = abs64(64'(dy_r)); opb = u_r; end
      ST_PZ:    begin opa = abs64(64'(dz_r)); opb = u_r; end
      default:  begin opa = '0; end
    endcase
  end

  hcms_arith u_arith (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.start),
    .op     (aop),
    .opa    (opa),
    .opb    (opb),
    .opc    (opc),
    .done   (u_done),
    .res_hi (u_hi),
    .res_lo (u_lo),
    .res_q  (u_q),
    .ovf    (u_ovf)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_r <= ONE_Q;
      drag_r <= '0;
      grav_r <= GRAV_Q;
      dgs_r <= ONE_Q;
      meter_r <= ONE_Q;
      minspd_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MASS:        mass_r <= cfg_data;
        REG_DRAG:        drag_r <= cfg_data;
        REG_GRAVITY:     grav_r <= cfg_data;
        REG_DEAD_SCALE:  dgs_r <= cfg_data;
        REG_METER_SCALE: meter_r <= cfg_data;
        REG_MIN_SPEED:   minspd_r <= cfg_data;
        default:         mass_r <= mass_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dx_r <= '0;
      dy_r <= '0;
      dz_r <= '0;
      speed_r <= '0;
      px_r <= '0;
      py_r <= '0;
      pz_r <= '0;
    end else if (u_done) begin
      case (cmd.step)
        ST_NDX: dx_r <= 16'(apply_sign(vx_r[63], u_q));
        ST_NDY: dy_r <= 16'(apply_sign(vy_r[63], u_q));
        ST_NDZ: dz_r <= 16'(apply_sign(vz_r[63], u_q));
        ST_PX:  px_r <= px_r + POS_WIDTH'(apply_sign(dx_r[15], sh_bd));
        ST_PY:  py_r <= py_r + POS_WIDTH'(apply_sign(dy_r[15], sh_bd));
        ST_PZ:  pz_r <= pz_r + POS_WIDTH'(apply_sign(dz_r[15], sh_bd));
        default: speed_r <= speed_r;
      endcase
    end else if (cmd.go) begin
      case (cmd.step)
        ST_NZERO: begin
          dx_r <= '0;
          dy_r <= '0;
          dz_r <= '0;
          speed_r <= '0;
        end
        ST_NFIN: speed_r <= (k_r || (n_r > SPEED_MAX)) ? SPEED_MAX[30:0] : n_r[30:0];
        default: speed_r <= speed_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_r <= in_time_step;
      dead_r <= in_dead;
      nof_r <= in_no_force;
      hx_r <= in_heading_x;
      hz_r <= in_heading_z;
      ux_r <= in_up_x;
      uz_r <= in_up_z;
      thrust_r <= in_thrust;
      lift_r <= in_lift;
      rx_r <= '0;
      rz_r <= '0;
    end else if (u_done) begin
      case (cmd.step)
        ST_G1, ST_G2: ry_r <= $signed(sh_ff);
        ST_HX2:   hs_r <= u_lo[32:0];
        ST_HZ2:   hs_r <= hs_r + u_lo[32:0];
        ST_HSQRT: nb_r <= u_q[16:0];
        ST_TXD:   rx_r <= apply_sign(thrust_r[31] ^ hx_r[15], dv_f);
        ST_TZD:   rz_r <= apply_sign(thrust_r[31] ^ hz_r[15], dv_f);
        ST_LX:    rx_r <= apply_sign(!(ux_r[15] ^ lift_r[31]), sh_fd);
        ST_LZ:    rz_r <= apply_sign(!(uz_r[15] ^ lift_r[31]), sh_fd);
        ST_DRAG:  lwv_r <= sh_ff;
        ST_DX:    rx_r <= clampf(rx_r - apply_sign(dx_r[15], sh_fd));
        ST_DY:    ry_r <= clampf(ry_r - apply_sign(dy_r[15], sh_fd));
        ST_DZ:    rz_r <= clampf(rz_r - apply_sign(dz_r[15], sh_fd));
        ST_VXA:   tmp_r <= apply_sign(dx_r[15], sh_bd);
        ST_VYA:   tmp_r <= apply_sign(dy_r[15], sh_bd);
        ST_VZA:   tmp_r <= apply_sign(dz_r[15], sh_bd);
        ST_VXD:   vx_r <= tmp_r + apply_sign(rx_r[63], dv_b);
        ST_VYD:   vy_r <= tmp_r + apply_sign(ry_r[63], dv_b);
        ST_VZD:   vz_r <= tmp_r + apply_sign(rz_r[63], dv_b);
        ST_SQX:   sq_r <= u_lo;
        ST_SQY, ST_SQZ: sq_r <= sq_r + u_lo;
        ST_NSQRT: n_r <= u_q[31:0];
        ST_U1, ST_U2: u_r <= sh_bf;
        default:  k_r <= k_r;
      endcase
    end else if (cmd.go) begin
      case (cmd.step)
        ST_LIFT: ry_r <= ry_r - 64'(lift_r);
        ST_MAG: begin
          ax_r <= abs64(vx_r);
          ay_r <= abs64(vy_r);
          az_r <= abs64(vz_r);
          k_r <= 1'b0;
        end
        ST_SHIFT: begin
          ax_r <= ax_r >> 1;
          ay_r <= ay_r >> 1;
          az_r <= az_r >> 1;
          k_r <= 1'b1;
        end
        default: k_r <= k_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.go && (cmd.step == ST_OUT)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go && (cmd.step == ST_OUT)) begin
      opx_r <= px_r;
      opy_r <= py_r;
      opz_r <= pz_r;
      odx_r <= dx_r;
      ody_r <= dy_r;
      odz_r <= dz_r;
      ospd_r <= speed_r;
      omoved_r <= moved_now;
    end
  end

  always_comb begin
    status.unit_done = u_done;
    status.dead = dead_r;
    status.no_force = nof_r;
    status.horiz = (hs_r > NEAR_VERTICAL_SQ);
    status.force_nz = (rx_r != 64'sd0) || (ry_r != 64'sd0) || (rz_r != 64'sd0);
    status.big = ((ax_r | ay_r | az_r) >> 31) != 64'd0;
    status.n_zero = (n_r == 32'd0);
    status.moved = moved_now;
    status.out_free = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_position_x_out = opx_r;
  assign out_position_y_out = opy_r;
  assign out_position_z_out = opz_r;
  assign out_direction_x_out = odx_r;
  assign out_direction_y_out = ody_r;
  assign out_direction_z_out = odz_r;
  assign out_speed_out = ospd_r;
  assign out_moved = omoved_r;

endmodule
`default_nettype wire
